[src/e2k_pkg.sv]
// Package for the Eulerian to kappa angle converter.
// Holds CORDIC constants, the arctangent table and shared types; no dependencies.
`timescale 1ns / 1ps

package e2k_pkg;

    localparam int ANGLE_BITS_DEF = 18;
    localparam int CORDIC_ITERS = 30;
    localparam int QFRAC = 30;
    localparam int TILT_SHIFT = 14;
    localparam logic signed [35:0] CORDIC_GAIN_INV = 36'sd652032874;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [15:0] TILT_RESET = 16'd36409;
    localparam logic ADDR_KAPPA_TILT = 1'b0;

    // Operation codes of the shared CORDIC unit.
    typedef enum logic [0:0] {
        CORDIC_ROTATE = 1'b0,
        CORDIC_VECTOR = 1'b1
    } cordic_op_t;

    // Request from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic              start;
        cordic_op_t        op;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [35:0] z;
    } cordic_req_t;

    // Answer from the CORDIC unit.
    typedef struct packed {
        logic              done;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [35:0] z;
    } cordic_rsp_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] arctan_lookup(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051D;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2E;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F;
                5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B;
                5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000028;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000002;
                5'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

[src/e2k_cordic.sv]
// Shared iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// Depends on e2k_pkg.
`timescale 1ns / 1ps

module e2k_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  e2k_pkg::cordic_req_t req,
    output e2k_pkg::cordic_rsp_t rsp
);

    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [35:0] x_next, y_next, z_next;
    logic [4:0] iter_reg;
    logic busy_reg, done_reg;
    e2k_pkg::cordic_op_t op_reg;
    logic signed [35:0] atan_val;
    logic go_pos;

    assign atan_val = $signed({4'b0, e2k_pkg::arctan_lookup(iter_reg)});

    // Direction and next values of the micro-rotation.
    always_comb begin
        if (op_reg == e2k_pkg::CORDIC_ROTATE) begin
            go_pos = (z_reg >= 0);
        end else begin
            go_pos = (y_reg < 0);
        end
        if (go_pos) begin
            x_next = x_reg - (y_reg >>> iter_reg);
            y_next = y_reg + (x_reg >>> iter_reg);
            z_next = z_reg - atan_val;
        end else begin
            x_next = x_reg + (y_reg >>> iter_reg);
            y_next = y_reg - (x_reg >>> iter_reg);
            z_next = z_reg + atan_val;
        end
    end

    // Iteration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                op_reg   <= req.op;
                x_reg    <= req.x;
                y_reg    <= req.y;
                z_reg    <= req.z;
            end else if (busy_reg) begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                if (iter_reg == 5'(e2k_pkg::CORDIC_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    iter_reg <= iter_reg + 5'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.x = x_reg;
    assign rsp.y = y_reg;
    assign rsp.z = z_reg;

endmodule

[src/e2k_isqrt.sv]
// Bit-serial integer square root, floor, one result bit per cycle.
// Uses nothing from e2k_pkg; stand-alone unit.
`timescale 1ns / 1ps

module e2k_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rem_reg, res_reg, bit_reg;
    logic busy_reg, done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    // One result bit per cycle, bit pattern walks down by two.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end else if (busy_reg) begin
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

[src/e2k_seq.sv]
// Sequencer: drives the shared CORDIC, square root and multiplier for one item.
// Depends on e2k_pkg, e2k_cordic and e2k_isqrt.
`timescale 1ns / 1ps

module e2k_seq #(
    parameter int ANGLE_BITS = e2k_pkg::ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] chi,
    input  logic [15:0]           tilt,
    output logic                  done,
    output logic                  err,
    output logic [31:0]           p_turn,
    output logic [31:0]           k_turn
);

    typedef enum logic [4:0] {
        S_IDLE, S_RC, S_WC, S_RA, S_WA, S_M1, S_M2, S_M3, S_M4,
        S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQ5, S_RT, S_WR, S_VEC, S_WV, S_DONE
    } state_t;

    state_t state_reg;
    logic phase_reg; // 0 computes p, 1 computes kappa
    logic done_reg, err_reg;
    logic signed [35:0] sc_reg, cc_reg, sa_reg, ca_reg, n_reg, d_reg;
    logic signed [35:0] chi_reg, alpha_reg;
    logic [63:0] acc_reg, nn_reg, rad_reg;
    logic [31:0] p_reg, k_reg, root_reg;
    logic isq_start;

    e2k_pkg::cordic_req_t creq;
    e2k_pkg::cordic_rsp_t crsp;
    logic isq_done;
    logic [31:0] isq_root;

    e2k_cordic u_cordic (.aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));
    e2k_isqrt u_isqrt (.aclk(aclk), .aresetn(aresetn), .start(isq_start),
                       .radicand(rad_reg), .done(isq_done), .root(isq_root));

    // Shared magnitude multiplier, one 32x32 product.
    logic signed [35:0] mul_a, mul_b;
    logic [31:0] mag_a, mag_b;
    logic [63:0] mul_p;
    always_comb begin
        mul_a = n_reg;
        mul_b = d_reg;
        unique case (state_reg)
            S_M1: begin mul_a = sc_reg; mul_b = ca_reg; end
            S_M2: begin mul_a = cc_reg; mul_b = sa_reg; end
            S_SQ1: begin mul_a = d_reg; mul_b = d_reg; end
            S_SQ2: begin mul_a = n_reg; mul_b = n_reg; end
            default: begin mul_a = n_reg; mul_b = d_reg; end
        endcase
        mag_a = mul_a[35] ? 32'(-mul_a) : mul_a[31:0];
        mag_b = mul_b[35] ? 32'(-mul_b) : mul_b[31:0];
        mul_p = mag_a * mag_b;
    end

    logic [63:0] rnd;
    assign rnd = (acc_reg + (64'd1 << (e2k_pkg::QFRAC - 1))) >> e2k_pkg::QFRAC;

    logic signed [31:0] chi32;
    logic [32:0] chi_mag;
    assign chi32 = $signed({chi, {(32 - ANGLE_BITS){1'b0}}});
    assign chi_mag = chi32[31] ? 33'(-$signed({chi32[31], chi32})) : {1'b0, chi32};

    always_comb begin
        creq = '0;
        isq_start = 1'b0;
        unique case (state_reg)
            S_RC: begin
                creq.start = 1'b1; creq.op = e2k_pkg::CORDIC_ROTATE;
                creq.x = e2k_pkg::CORDIC_GAIN_INV; creq.z = chi_reg >>> 1;
            end
            S_RA: begin
                creq.start = 1'b1; creq.op = e2k_pkg::CORDIC_ROTATE;
                creq.x = e2k_pkg::CORDIC_GAIN_INV; creq.z = alpha_reg;
            end
            S_VEC: begin
                creq.start = 1'b1; creq.op = e2k_pkg::CORDIC_VECTOR;
                creq.x = $signed({4'b0, root_reg}); creq.y = n_reg;
            end
            S_SQ4: isq_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (start) begin
                    chi_reg   <= 36'(chi32);
                    alpha_reg <= 36'({tilt, {e2k_pkg::TILT_SHIFT{1'b0}}});
                    phase_reg <= 1'b0;
                    if (chi_mag > 33'({tilt, {(e2k_pkg::TILT_SHIFT + 1){1'b0}}})) begin
                        err_reg <= 1'b1; state_reg <= S_DONE;
                    end else begin
                        err_reg <= 1'b0; state_reg <= S_RC;
                    end
                end
                S_RC: state_reg <= S_WC;
                S_WC: if (crsp.done) begin
                    sc_reg <= crsp.y; cc_reg <= crsp.x; state_reg <= S_RA;
                end
                S_RA: state_reg <= S_WA;
                S_WA: if (crsp.done) begin
                    sa_reg <= crsp.y; ca_reg <= crsp.x; state_reg <= S_M1;
                end
                // n = sc*ca rounded, sign applied.
                S_M1: begin acc_reg <= mul_p; state_reg <= S_M2; end
                S_M2: begin
                    n_reg <= ((sc_reg < 0) != (ca_reg < 0)) ? -$signed({4'b0, rnd[31:0]})
                                                           : $signed({4'b0, rnd[31:0]});
                    acc_reg <= mul_p; state_reg <= S_M3;
                end
                S_M3: begin
                    d_reg <= ((cc_reg < 0) != (sa_reg < 0)) ? -$signed({4'b0, rnd[31:0]})
                                                           : $signed({4'b0, rnd[31:0]});
                    state_reg <= S_SQ1;
                end
                S_M4: begin n_reg <= sc_reg; d_reg <= sa_reg; state_reg <= S_SQ1; end
                S_SQ1: begin acc_reg <= mul_p; state_reg <= S_SQ2; end
                S_SQ2: begin nn_reg <= mul_p; state_reg <= S_SQ3; end
                S_SQ3: begin
                    rad_reg <= (acc_reg > nn_reg) ? acc_reg - nn_reg : '0;
                    state_reg <= S_SQ4;
                end
                S_SQ4: state_reg <= S_RT;
                S_RT: if (isq_done) begin root_reg <= isq_root; state_reg <= S_WR; end
                S_WR: begin
                    if (n_reg == 0) begin
                        if (phase_reg) begin k_reg <= '0; state_reg <= S_DONE; end
                        else begin p_reg <= '0; phase_reg <= 1'b1; state_reg <= S_M4; end
                    end else begin
                        state_reg <= S_VEC;
                    end
                end
                S_VEC: state_reg <= S_WV;
                S_WV: if (crsp.done) begin
                    if (phase_reg) begin
                        k_reg <= crsp.z[31:0]; state_reg <= S_DONE;
                    end else begin
                        p_reg <= crsp.z[31:0]; phase_reg <= 1'b1; state_reg <= S_M4;
                    end
                end
                S_DONE: begin done_reg <= 1'b1; state_reg <= S_IDLE; end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign err = err_reg;
    assign p_turn = p_reg;
    assign k_turn = k_reg;

endmodule

[src/eulerian_to_kappa_angles_core.sv]
// Top level of the Eulerian to kappa angle converter: handshakes, APB register, axis store.
// Depends on e2k_pkg and e2k_seq.
`timescale 1ns / 1ps
//
// Channel  | Direction | Content
// s_axis   | in        | tuser {opcode, strict}, tdata {omega, chi, phi, det, mu, gamma}
// m_axis   | out       | tdata {mu, komega, kappa, kphi, gamma, delta, error}
// apb      | in        | kappa_tilt at address 0
//
// A result is valid once its item has passed two CORDIC rotations, two vectoring passes,
// two bit-serial square roots, and the multiply and handshake steps. A zero numerator
// skips its vectoring pass. An out-of-range chi skips all of these passes.
// Reset is synchronous and active low.
// The input is not ready while an item is in work or its result waits on m_axis.

module eulerian_to_kappa_angles_core #(
    parameter int ANGLE_BITS = e2k_pkg::ANGLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // bits from low: omega, chi, phi, detector_angle, source_mu, source_gamma, zero fill
    input  logic [((6*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // bits from low: opcode, strict
    input  logic [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // bits from low: mu, komega, kappa_axis, kphi, gamma, delta, error, zero fill
    output logic [((6*ANGLE_BITS+8)/8)*8-1:0] m_axis_tdata,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int OUT_W = ((6*ANGLE_BITS+8)/8)*8;
    localparam int SHIFT = 32 - ANGLE_BITS;

    logic [15:0] tilt_reg;
    logic [ANGLE_BITS-1:0] mu_reg, kom_reg, kap_reg, kph_reg, gam_reg, del_reg;
    logic [ANGLE_BITS-1:0] om_reg, ph_reg, dt_reg, smu_reg, sga_reg;
    logic op_reg, strict_reg, busy_reg, out_valid_reg, err_reg;
    logic seq_done, seq_err;
    logic [31:0] p_turn, k_turn;
    logic in_fire;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == e2k_pkg::ADDR_KAPPA_TILT) ? {16'b0, tilt_reg} : '0;

    assign s_axis_tready = !busy_reg && !out_valid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    e2k_seq #(.ANGLE_BITS(ANGLE_BITS)) u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(in_fire),
        .chi(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .tilt(tilt_reg),
        .done(seq_done), .err(seq_err), .p_turn(p_turn), .k_turn(k_turn)
    );

    // Round a turn-scaled 32-bit angle to the output width.
    function automatic logic [ANGLE_BITS-1:0] rnd_turn(input logic [31:0] v);
        logic [32:0] s;
        begin
            s = {1'b0, v} + 33'((64'd1 << SHIFT) >> 1);
            return s[31 -: ANGLE_BITS];
        end
    endfunction

    logic [31:0] om32, ph32;
    assign om32 = {om_reg, {SHIFT{1'b0}}};
    assign ph32 = {ph_reg, {SHIFT{1'b0}}};

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_reg <= e2k_pkg::TILT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == e2k_pkg::ADDR_KAPPA_TILT) begin
            tilt_reg <= pwdata[15:0];
        end
    end

    // Item capture, axis store and output holding register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; out_valid_reg <= 1'b0; err_reg <= 1'b0;
            mu_reg <= '0; kom_reg <= '0; kap_reg <= '0;
            kph_reg <= '0; gam_reg <= '0; del_reg <= '0;
        end else begin
            if (in_fire) begin
                busy_reg   <= 1'b1;
                om_reg     <= s_axis_tdata[ANGLE_BITS-1:0];
                ph_reg     <= s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];
                dt_reg     <= s_axis_tdata[4*ANGLE_BITS-1:3*ANGLE_BITS];
                smu_reg    <= s_axis_tdata[5*ANGLE_BITS-1:4*ANGLE_BITS];
                sga_reg    <= s_axis_tdata[6*ANGLE_BITS-1:5*ANGLE_BITS];
                op_reg     <= s_axis_tuser[0];
                strict_reg <= s_axis_tuser[1];
            end
            if (seq_done) begin
                busy_reg <= 1'b0; out_valid_reg <= 1'b1; err_reg <= seq_err;
                if (!seq_err) begin
                    kom_reg <= rnd_turn(om32 + p_turn - e2k_pkg::QUARTER_TURN);
                    kap_reg <= rnd_turn(32'd0 - {k_turn[30:0], 1'b0});
                    kph_reg <= rnd_turn(ph32 + p_turn + e2k_pkg::QUARTER_TURN);
                    del_reg <= dt_reg;
                    if (op_reg) begin
                        mu_reg <= smu_reg; gam_reg <= sga_reg;
                    end else if (strict_reg) begin
                        mu_reg <= '0; gam_reg <= '0;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_W'({err_reg, del_reg, gam_reg, kph_reg, kap_reg, kom_reg, mu_reg});

endmodule

[src/e2k_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on eulerian_to_kappa_angles_core ports only.
`timescale 1ns / 1ps

module e2k_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        pready
);

    // No new item is taken while a result waits.
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result pending");

    // An accepted item is not answered in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

    // After accepting, the input stays closed for the next cycle.
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");

    // Result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");

    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");

endmodule

bind eulerian_to_kappa_angles_core e2k_checker u_e2k_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .pready(pready)
);

[bench/tb_eulerian_to_kappa_angles_core.sv]
// Testbench for the Eulerian to kappa angle converter core.
// Drives items and tilt register writes, predicts each result in fixed point and compares.
// Depends on e2k_pkg and eulerian_to_kappa_angles_core.
`timescale 1ns / 1ps

module tb_eulerian_to_kappa_angles_core;

    localparam int AB = 18;
    localparam int SW = ((6*AB+7)/8)*8;
    localparam int MW = ((6*AB+8)/8)*8;
    localparam int N_RANDOM = 600;
    localparam int STALL_LEN = 400;
    localparam bit SIX_CIRCLE = 1'b1;
    localparam bit FOUR_CIRCLE = 1'b0;

    // One Eulerian angle set with its source kind.
    typedef struct packed {
        logic       strict;
        logic       opcode;
        logic [AB-1:0] gam, smu, det, phi, chi, om;
    } euler_item_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    // bits from low: omega, chi, phi, detector_angle, source_mu, source_gamma, zero fill
    logic [SW-1:0] s_axis_tdata = '0;
    // bits from low: opcode, strict
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    // bits from low: mu, komega, kappa_axis, kphi, gamma, delta, error, zero fill
    logic [MW-1:0] m_axis_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    eulerian_to_kappa_angles_core #(.ANGLE_BITS(AB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    euler_item_t pending_items[$];
    logic [MW-1:0] expected_results[$];
    logic [15:0] tilt_model;
    logic [AB-1:0] axes_model[6];
    int errors = 0;
    bit quiet = 0;        // no idling in the last part of the run
    bit hold_receiver = 0;
    bit in_taken = 0;     // an item was accepted at the last rising edge
    int send_gap = 0, recv_gap = 0, hold_count = 0;

    // Arithmetic shift right with floor on a 64-bit value.
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // Sine and cosine of a 32-bit-turn angle by rotation CORDIC.
    function automatic void sin_cos(longint z, output longint sn, output longint cs);
        longint x, y, nx, ny;
        x = 652032874; y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i); ny = y + asr(x, i);
                z -= longint'(e2k_pkg::arctan_lookup(5'(i)));
            end else begin
                nx = x + asr(y, i); ny = y - asr(x, i);
                z += longint'(e2k_pkg::arctan_lookup(5'(i)));
            end
            x = nx; y = ny;
        end
        sn = y; cs = x;
    endfunction

    // Angle of the vector (x, y) by vectoring CORDIC; zero when y is zero.
    function automatic longint vector_angle(longint y, longint x);
        longint z, nx, ny;
        z = 0;
        if (y == 0) return 0;
        for (int i = 0; i < 30; i++) begin
            if (y >= 0) begin
                nx = x + asr(y, i); ny = y - asr(x, i);
                z += longint'(e2k_pkg::arctan_lookup(5'(i)));
            end else begin
                nx = x - asr(y, i); ny = y + asr(x, i);
                z -= longint'(e2k_pkg::arctan_lookup(5'(i)));
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic longint unsigned mag(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    // Product of two Q30 values rounded half away from zero.
    function automatic longint qprod(longint a, longint b);
        longint unsigned r;
        r = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0; b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b; res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint arcsine_of_ratio(longint n, longint d);
        longint unsigned dd, nn, rad;
        dd = mag(d) * mag(d);
        nn = mag(n) * mag(n);
        rad = dd > nn ? dd - nn : 0;
        return vector_angle(n, longint'(floor_sqrt(rad)));
    endfunction

    function automatic logic [AB-1:0] round_angle(logic [31:0] v);
        longint unsigned t;
        t = (longint'(v) + (64'd1 << (31 - AB))) >> (32 - AB);
        return t[AB-1:0];
    endfunction

    // Converts one item against the model state and returns the packed result.
    function automatic logic [MW-1:0] convert_item(euler_item_t it);
        logic [31:0] om, ch, ph, pu, ku;
        longint chi_s, alpha, sc, cc, sa, ca, p, k;
        bit err;
        logic [MW-1:0] r;
        om = {it.om, {(32-AB){1'b0}}};
        ch = {it.chi, {(32-AB){1'b0}}};
        ph = {it.phi, {(32-AB){1'b0}}};
        chi_s = longint'(signed'(ch));
        alpha = longint'(tilt_model) << 14;
        err = mag(chi_s) > longint'(2 * alpha);
        if (!err) begin
            sin_cos(asr(chi_s, 1), sc, cc);
            sin_cos(alpha, sa, ca);
            p = arcsine_of_ratio(qprod(sc, ca), qprod(cc, sa));
            k = arcsine_of_ratio(sc, sa);
            pu = p[31:0]; ku = k[31:0];
            axes_model[1] = round_angle(om + pu - e2k_pkg::QUARTER_TURN);
            axes_model[2] = round_angle(32'd0 - 2 * ku);
            axes_model[3] = round_angle(ph + pu + e2k_pkg::QUARTER_TURN);
            axes_model[5] = it.det;
            if (it.opcode == SIX_CIRCLE) begin
                axes_model[0] = it.smu; axes_model[4] = it.gam;
            end else if (it.strict) begin
                axes_model[0] = '0; axes_model[4] = '0;
            end
        end
        r = '0;
        for (int i = 0; i < 6; i++) r[i*AB +: AB] = axes_model[i];
        r[6*AB] = err;
        return r;
    endfunction

    // Driver: offers queued items, with random idle bursts.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) void'(pending_items.pop_front());
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 0;
            end else if ((in_taken || !s_axis_tvalid) && !quiet
                         && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 19);
                s_axis_tvalid <= 0;
            end else if (pending_items.size() > 0 && (!s_axis_tvalid || in_taken)) begin
                s_axis_tvalid <= 1;
                s_axis_tdata <= SW'(pending_items[0][6*AB-1:0]);
                s_axis_tuser <= {pending_items[0].strict, pending_items[0].opcode};
            end else if (in_taken) begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // Prediction at each accepted item.
    always @(posedge aclk) begin
        euler_item_t it;
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            it = {s_axis_tuser[1], s_axis_tuser[0], s_axis_tdata[6*AB-1:0]};
            expected_results.push_back(convert_item(it));
        end
    end

    // Receiver readiness: random stalls and a long hold-off when asked.
    always @(negedge aclk) begin
        if (hold_receiver && hold_count < STALL_LEN) begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(1, 19);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= aresetn;
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        logic [MW-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                for (int i = 0; i < 6; i++)
                    if (m_axis_tdata[i*AB +: AB] !== want[i*AB +: AB]) begin
                        $display("%0t: axis %0d expected %h actual %h", $time, i,
                                 want[i*AB +: AB], m_axis_tdata[i*AB +: AB]);
                        errors++;
                    end
                if (m_axis_tdata[6*AB] !== want[6*AB]) begin
                    $display("%0t: error flag expected %b actual %b", $time,
                             want[6*AB], m_axis_tdata[6*AB]);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // APB write of the tilt register; the block must be idle.
    task automatic write_tilt(logic [15:0] v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= {e2k_pkg::ADDR_KAPPA_TILT, 2'b00};
        pwdata <= {16'd0, v};
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        tilt_model = v;
    endtask

    function automatic logic [AB-1:0] rand_angle();
        return AB'($urandom);
    endfunction

    // Random item; chi is mostly kept within twice the tilt.
    function automatic euler_item_t rand_item();
        euler_item_t it;
        logic [127:0] raw;
        int lim;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(euler_item_t)-1:0];
        lim = 2 * int'(tilt_model);
        if ($urandom_range(0, 4) != 0) it.chi = AB'($signed($urandom_range(0, 2*lim)) - lim);
        return it;
    endfunction

    task automatic add_item(bit op, bit st, int o, int c, int p, int d, int m, int g);
        euler_item_t it;
        it = {st, op, AB'(g), AB'(m), AB'(d), AB'(p), AB'(c), AB'(o)};
        pending_items.push_back(it);
    endtask

    initial begin
        logic [15:0] tilts[6];
        int lim;
        tilt_model = e2k_pkg::TILT_RESET;
        for (int i = 0; i < 6; i++) axes_model[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed items with the reset tilt: extremes, both sources, strict, chi limit.
        lim = 2 * int'(e2k_pkg::TILT_RESET);
        add_item(FOUR_CIRCLE, 1'b0, 0, 0, 0, 0, 0, 0);
        add_item(SIX_CIRCLE, 1'b0, 131071, 1000, -131072, 131071, -131072, 131071);
        add_item(FOUR_CIRCLE, 1'b0, -131072, -1000, 131071, -131072, 5, 5);
        add_item(FOUR_CIRCLE, 1'b1, 100, lim, 200, 300, 7, 7);
        add_item(SIX_CIRCLE, 1'b1, 100, -lim, 200, 300, -1, -1);
        add_item(FOUR_CIRCLE, 1'b1, 1, lim + 1, 2, 3, 4, 5);
        add_item(SIX_CIRCLE, 1'b0, 1, -lim - 1, 2, 3, 4, 5);
        add_item(SIX_CIRCLE, 1'b0, 1, -131072, 2, 3, 4, 5);
        add_item(FOUR_CIRCLE, 1'b0, 1, 131071, 2, 3, 4, 5);
        add_item(SIX_CIRCLE, 1'b0, -1, -1, -1, -1, -1, -1);
        wait_drained();

        // Tilt extremes, with chi zero, chi at and just past the limit, and random items.
        tilts = '{16'd1, 16'd65535, 16'd16384, 16'd50000, 16'd36409, 16'd4};
        foreach (tilts[t]) begin
            write_tilt(tilts[t]);
            lim = 2 * int'(tilts[t]);
            add_item(SIX_CIRCLE, 1'b0, 10, 0, 20, 30, 40, 50);
            add_item(FOUR_CIRCLE, 1'b1, 10, lim, 20, 30, 40, 50);
            add_item(SIX_CIRCLE, 1'b1, 10, lim + 1, 20, 30, 40, 50);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if (t == 5 && i > N_RANDOM / 12) quiet = 1;
                pending_items.push_back(rand_item());
                if (t == 1 && i == 5) hold_receiver = 1;
                if (pending_items.size() > 4) wait (pending_items.size() <= 4);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
